>>> rtl/rfps_pkg.sv
// ============================================================================
// rfps_pkg: shared types and constants for the range frame parser
// Frame phase codes, byte codes, register map and the records that pass
// between the parser, the speed unit and the top level.
// ============================================================================
package rfps_pkg;

    localparam int DIST_W  = 14;
    localparam int SPEED_W = 22;
    localparam int SCALE_W = 8;
    localparam int PHASE_W = 3;

    // Frame phases: idle, four digit slots, skip to carriage return
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_D1   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_D2   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_D3   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_D4   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SKIP = 3'd5;

    localparam logic [7:0] START_BYTE = 8'h52;  // 'R'
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] NINE_CHAR  = 8'h39;

    // Register map, index = paddr[3:2]
    localparam logic [1:0] REG_MIN_DIST  = 2'd0;
    localparam logic [1:0] REG_MAX_DIST  = 2'd1;
    localparam logic [1:0] REG_SPD_SCALE = 2'd2;

    localparam logic [DIST_W-1:0]  MIN_DIST_RST  = 14'd300;
    localparam logic [DIST_W-1:0]  MAX_DIST_RST  = 14'd5000;
    localparam logic [SCALE_W-1:0] SPD_SCALE_RST = 8'd36;

    typedef struct packed {
        logic [DIST_W-1:0]  min_dist;
        logic [DIST_W-1:0]  max_dist;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    // Completed-frame event from the parser
    typedef struct packed {
        logic              done;
        logic              bad;
        logic [DIST_W-1:0] distance;
    } frame_evt_t;

    // Speed unit view after the frame
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               toward;
        logic               fresh;
        logic               pair_end;
    } speed_res_t;

endpackage

>>> rtl/range_frame_parser_speed.sv
// ============================================================================
// range_frame_parser_speed: ultrasonic ranger frame parser with speed estimate
// Parses 'R' + digits + CR frames from a serial byte stream and reports each
// reading together with a held speed computed over pairs of frames.
// ============================================================================
// The block takes one received byte per input transfer and can take one
// every clock cycle while the result side is not stalled: a byte goes into
// an input register, is parsed and, when it completes a frame, the result
// is registered in an output register. Input and output registers sit
// between the two sides; a stalled result holds the byte behind it, and
// the full input register then refuses new bytes. Each completed frame
// (carriage return after four digits, or a non-digit where a digit is due)
// yields one output transfer; all other bytes yield none. Frames alternate
// first/second of a pair; on the second frame the speed |second - first| *
// speed_scale is updated when both readings lie strictly inside
// (min_distance, max_distance), and zeroed when the second reading equals
// min_distance. m_tlast marks the second frame of a pair. Registers sit at
// byte addresses 0, 4, 8 and should be written only while the stream is idle.
module range_frame_parser_speed
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [13:0] distance, [35:14] speed, [36] toward, zero fill
    output logic        m_tlast,    // pair_end
    output logic [1:0]  m_tuser,    // [0] speed_fresh, [1] malformed
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rfps_pkg::*;

    cfg_t               cfg_reg;
    logic               cfg_wr;

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    speed_res_t         out_res_reg;
    logic               out_bad_reg;

    logic               out_free;
    logic               proc;
    frame_evt_t         evt;
    speed_res_t         res;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_dist <= MIN_DIST_RST;
            cfg_reg.max_dist <= MAX_DIST_RST;
            cfg_reg.scale    <= SPD_SCALE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MIN_DIST:  cfg_reg.min_dist <= pwdata[DIST_W-1:0];
                REG_MAX_DIST:  cfg_reg.max_dist <= pwdata[DIST_W-1:0];
                REG_SPD_SCALE: cfg_reg.scale    <= pwdata[SCALE_W-1:0];
                default:       ;  // drop writes outside the map
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MIN_DIST:  prdata = {{(32-DIST_W){1'b0}}, cfg_reg.min_dist};
            REG_MAX_DIST:  prdata = {{(32-DIST_W){1'b0}}, cfg_reg.max_dist};
            REG_SPD_SCALE: prdata = {{(32-SCALE_W){1'b0}}, cfg_reg.scale};
            default:       prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // The held byte advances when the result slot is empty or drains this
    // cycle; the input register refills whenever its byte advances.
    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    // ---------------- datapath ----------------
    rfps_frame u_frame
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (proc),
        .rx_byte (in_byte_reg),
        .evt     (evt)
    );

    rfps_speed u_speed
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (proc),
        .evt   (evt),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= proc && evt.done;
    end

    always_ff @(posedge clk)
    begin
        if (proc && evt.done)
        begin
            out_dist_reg <= evt.distance;
            out_res_reg  <= res;
            out_bad_reg  <= evt.bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.toward, out_res_reg.speed, out_dist_reg};
    assign m_tlast  = out_res_reg.pair_end;
    assign m_tuser  = {out_bad_reg, out_res_reg.fresh};

endmodule

>>> rtl/rfps_frame.sv
// ============================================================================
// rfps_frame: ASCII frame parser
// Waits for the start byte, gathers up to four decimal digits and skips to
// the carriage return; flags a frame cut short by a non-digit.
// ============================================================================
module rfps_frame
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [7:0]                rx_byte,
    output rfps_pkg::frame_evt_t      evt
);
    import rfps_pkg::*;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [DIST_W-1:0]  accum_reg;
    logic [DIST_W-1:0]  accum_next;
    logic               is_digit;
    logic [DIST_W+2:0]  mac;

    assign is_digit = (rx_byte >= ZERO_CHAR) && (rx_byte <= NINE_CHAR);
    // accum * 10 + digit, wrapped to the accumulator width
    assign mac = {accum_reg, 3'b000} + {2'b00, accum_reg, 1'b0}
               + {{(DIST_W-1){1'b0}}, rx_byte[3:0]};

    always_comb
    begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        evt.done     = 1'b0;
        evt.bad      = 1'b0;
        evt.distance = accum_reg;
        case (phase_reg)
            PH_D1, PH_D2, PH_D3, PH_D4:
            begin
                if (is_digit)
                begin
                    accum_next = mac[DIST_W-1:0];
                    phase_next = (phase_reg == PH_D4) ? PH_SKIP : phase_reg + 3'd1;
                end
                else
                begin
                    evt.done   = 1'b1;
                    evt.bad    = 1'b1;
                    phase_next = PH_IDLE;
                    accum_next = '0;
                end
            end
            PH_SKIP:
            begin
                if (rx_byte == CR_BYTE)
                begin
                    evt.done   = 1'b1;
                    phase_next = PH_IDLE;
                    accum_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (rx_byte == START_BYTE)
                begin
                    phase_next = PH_D1;
                    accum_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            accum_reg <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
        end
    end

endmodule

>>> rtl/rfps_speed.sv
// ============================================================================
// rfps_speed: pairwise speed estimate
// Stores the first reading of a pair, and on the second one computes and
// holds |diff| * scale with direction if both lie in window; 0 at min_dist.
// ============================================================================
module rfps_speed
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  rfps_pkg::frame_evt_t  evt,
    input  rfps_pkg::cfg_t        cfg,
    output rfps_pkg::speed_res_t  res
);
    import rfps_pkg::*;

    logic                pair_second_reg;
    logic [DIST_W-1:0]   first_reading_reg;
    logic                first_in_range_reg;
    logic [SPEED_W-1:0]  held_speed_reg;
    logic                held_toward_reg;

    logic                cur_in_range;
    logic                first_larger;
    logic [DIST_W-1:0]   diff;
    logic [SPEED_W-1:0]  product;

    assign cur_in_range = (evt.distance > cfg.min_dist) && (evt.distance < cfg.max_dist);
    assign first_larger = first_reading_reg > evt.distance;
    assign diff = first_larger ? (first_reading_reg - evt.distance)
                               : (evt.distance - first_reading_reg);
    // 14 x 8 bits never exceeds the 22-bit result
    assign product = SPEED_W'(diff) * SPEED_W'(cfg.scale);

    always_comb
    begin
        res.speed    = held_speed_reg;
        res.toward   = held_toward_reg;
        res.fresh    = 1'b0;
        res.pair_end = pair_second_reg;
        if (pair_second_reg)
        begin
            if (first_in_range_reg && cur_in_range)
            begin
                res.speed  = product;
                res.toward = first_larger;
                res.fresh  = 1'b1;
            end
            if (evt.distance == cfg.min_dist)
            begin
                res.speed = '0;
                res.fresh = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_second_reg    <= 1'b0;
            first_reading_reg  <= '0;
            first_in_range_reg <= 1'b0;
            held_speed_reg     <= '0;
            held_toward_reg    <= 1'b0;
        end
        else if (en && evt.done)
        begin
            pair_second_reg <= !pair_second_reg;
            held_speed_reg  <= res.speed;
            held_toward_reg <= res.toward;
            if (!pair_second_reg)
            begin
                first_reading_reg  <= evt.distance;
                first_in_range_reg <= cur_in_range;
            end
        end
    end

endmodule
